>>> design/css_pkg.sv
// Shared types, constants and helpers for the closest segment search unit.
`timescale 1ns / 1ps
package css_pkg;

  localparam int MAX_SEGMENTS = 1024;
  localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int DIV_STEPS = 32;

  localparam logic [62:0] DIST_MAX = {63{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index as decoded from the word address
  localparam logic REG_EDGE_COUNT = 1'b0;

  typedef struct packed {
    logic signed [31:0] start_u;
    logic signed [31:0] start_v;
    logic signed [32:0] dir_u;
    logic signed [32:0] dir_v;
    logic [63:0]        length_sq;
    logic [19:0]        triangle;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_U,
    ST_LEN_V,
    ST_LEN_WR,
    ST_RD,
    ST_W,
    ST_DOT_U,
    ST_DOT_V,
    ST_LERP,
    ST_DIV,
    ST_PU,
    ST_PV,
    ST_CU,
    ST_CV,
    ST_CMP,
    ST_OUT
  } st_e;

  function automatic logic [33:0] mag35(input logic signed [34:0] x);
    logic signed [34:0] n;
    n = -x;
    return x[34] ? n[33:0] : x[33:0];
  endfunction

endpackage

>>> design/css_intf.sv
// Request and response stream interfaces.
`timescale 1ns / 1ps
interface css_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [9:0]         slot;
  logic signed [31:0] start_u;
  logic signed [31:0] start_v;
  logic signed [31:0] end_u;
  logic signed [31:0] end_v;
  logic [19:0]        owner_triangle;
  logic signed [31:0] query_u;
  logic signed [31:0] query_v;

  modport source (output valid, opcode, slot, start_u, start_v, end_u, end_v,
                  owner_triangle, query_u, query_v, input ready);
  modport sink (input valid, opcode, slot, start_u, start_v, end_u, end_v,
                owner_triangle, query_u, query_v, output ready);
endinterface

interface css_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  closest_edge;
  logic [19:0] triangle;
  logic [62:0] distance_squared;
  logic        table_empty;

  modport source (output valid, closest_edge, triangle, distance_squared,
                  table_empty, input ready);
  modport sink (input valid, closest_edge, triangle, distance_squared,
                table_empty, output ready);
endinterface

>>> design/css_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module css_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/css_mul.sv
// 34x34 unsigned multiplier, summing two 34x17 partial products in turn, low half first.
`timescale 1ns / 1ps
module css_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] a_i,
  input  logic [33:0] b_i,
  output logic        done_o,
  output logic [67:0] prod_o
);
  import css_pkg::*;

  logic [33:0] a_q, b_q;
  logic [67:0] acc_q;
  logic [1:0]  ph_q;
  logic        done_q;
  logic [50:0] part;

  assign part = a_q * (ph_q[0] ? b_q[16:0] : b_q[33:17]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (ph_q == 2'd2);
      if (start_i) begin
        ph_q <= 2'd1;
      end else if (ph_q == 2'd1) begin
        ph_q <= 2'd2;
      end else begin
        ph_q <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (ph_q == 2'd1) begin
      acc_q <= {17'd0, part};
    end else if (ph_q == 2'd2) begin
      acc_q <= acc_q + {part, 17'd0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> design/css_div.sv
// Restoring divider: floor(num * 2^32 / den) for num < den, one bit a cycle.
`timescale 1ns / 1ps
module css_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  import css_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [63:0] rem_q, den_q;
  logic [31:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic        done_q;
  logic [64:0] shl;
  logic [64:0] dif;
  logic        ge;

  assign shl = {rem_q, 1'b0};
  assign dif = shl - {1'b0, den_q};
  assign ge  = (shl >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(DIV_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      // remainder stays below den, so the low 64 bits hold it
      rem_q <= ge ? dif[63:0] : shl[63:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> design/closest_segment_search_unit.sv
// Top level: segment table, per-segment distance sequencer and register port.
// A load computes two squares through the shared multiplier. A query runs
// the distance sequence once per searched segment, with the bit-serial
// divider as well for each segment whose lerp needs it. One item is worked
// at a time. Reset clears control state and edge_count; the table is
// undefined until written.
`timescale 1ns / 1ps
module closest_segment_search_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  css_req_if.sink       req_i,
  css_rsp_if.source     rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import css_pkg::*;

  st_e st_q, st_d;

  logic [10:0]       cnt_q;
  logic [CNT_W-1:0]  n_q, n_d, i_q;
  logic              mul_pend_q, div_pend_q;
  logic              mul_start, div_start, mul_done, div_done;
  logic [33:0]       mul_a, mul_b;
  logic [67:0]       mul_p;
  logic [31:0]       div_q;
  logic              req_fire, rsp_fire, out_fire;

  logic signed [31:0] qu_q, qv_q, su_q, sv_q;
  logic signed [32:0] du_q, dv_q, wu_q, wv_q;
  logic [63:0]        len_q;
  logic [19:0]        tri_q;
  logic [9:0]         slot_q;
  logic signed [68:0] dot_q, term;
  logic [32:0]        lerp_q;
  logic signed [33:0] pu_q, pv_q;
  logic signed [34:0] cu, cv;
  logic [68:0]        dist_q;
  logic [62:0]        dsat, best_d_q;
  logic [ADDR_W-1:0]  best_i_q;
  logic [19:0]        best_tri_q;
  logic               neg, lerp_zero, lerp_one, slot_ok;
  logic [67:0]        rnd;

  logic        rsp_valid_q, rsp_empty_q;
  logic [9:0]  rsp_edge_q;
  logic [19:0] rsp_tri_q;
  logic [62:0] rsp_dist_q;

  seg_t rd, wr;
  logic [SEG_W-1:0] rdata;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_valid_q && rsp_o.ready;
  assign out_fire = (st_q == ST_OUT) && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = (st_q == ST_IDLE);

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EDGE_COUNT) ? {21'd0, cnt_q} : 32'd0;

  always_comb begin
    if (32'(cnt_q) > 32'(MAX_SEGMENTS)) begin
      n_d = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_d = CNT_W'(cnt_q);
    end
  end

  // segment table
  assign rd = seg_t'(rdata);
  assign slot_ok = (32'(slot_q) < 32'(MAX_SEGMENTS));
  assign wr = '{start_u: su_q, start_v: sv_q, dir_u: du_q, dir_v: dv_q,
                length_sq: (dist_q[68:64] != '0) ? {64{1'b1}} : dist_q[63:0],
                triangle: tri_q};

  css_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    ((st_q == ST_LEN_WR) && slot_ok),
    .waddr_i (ADDR_W'(slot_q)),
    .wdata_i (wr),
    .raddr_i (i_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  css_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  css_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dot_q[63:0]),
    .den_i   (len_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign lerp_zero = (len_q == '0) || (dot_q <= 69'sd0);
  assign lerp_one  = (dot_q >= $signed({5'd0, len_q}));
  assign cu   = 35'(pu_q) - 35'(wu_q);
  assign cv   = 35'(pv_q) - 35'(wv_q);
  assign term = neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign rnd  = mul_p + 68'h8000_0000;
  assign dsat = (dist_q > {6'd0, DIST_MAX}) ? DIST_MAX : dist_q[62:0];

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.opcode == OP_LOAD) begin
            st_d = ST_LEN_U;
          end else if (n_d == '0) begin
            st_d = ST_OUT;
          end else begin
            st_d = ST_RD;
          end
        end
      end
      ST_LEN_U:  if (mul_done) st_d = ST_LEN_V;
      ST_LEN_V:  if (mul_done) st_d = ST_LEN_WR;
      ST_LEN_WR: st_d = ST_IDLE;
      ST_RD:     st_d = ST_W;
      ST_W:      st_d = ST_DOT_U;
      ST_DOT_U:  if (mul_done) st_d = ST_DOT_V;
      ST_DOT_V:  if (mul_done) st_d = ST_LERP;
      ST_LERP:   st_d = (lerp_zero || lerp_one) ? ST_PU : ST_DIV;
      ST_DIV:    if (div_done) st_d = ST_PU;
      ST_PU:     if (mul_done) st_d = ST_PV;
      ST_PV:     if (mul_done) st_d = ST_CU;
      ST_CU:     if (mul_done) st_d = ST_CV;
      ST_CV:     if (mul_done) st_d = ST_CMP;
      ST_CMP:    st_d = (i_q + CNT_W'(1) == n_q) ? ST_OUT : ST_RD;
      ST_OUT:    if (out_fire) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // FSM outputs: multiplier operands and unit starts
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg   = 1'b0;
    unique case (st_q)
      ST_LEN_U: begin mul_a = mag35(35'(du_q)); mul_b = mag35(35'(du_q)); end
      ST_LEN_V: begin mul_a = mag35(35'(dv_q)); mul_b = mag35(35'(dv_q)); end
      ST_DOT_U: begin
        mul_a = mag35(35'(wu_q));
        mul_b = mag35(35'(du_q));
        neg   = wu_q[32] ^ du_q[32];
      end
      ST_DOT_V: begin
        mul_a = mag35(35'(wv_q));
        mul_b = mag35(35'(dv_q));
        neg   = wv_q[32] ^ dv_q[32];
      end
      ST_PU: begin mul_a = mag35(35'(du_q)); mul_b = {1'b0, lerp_q}; end
      ST_PV: begin mul_a = mag35(35'(dv_q)); mul_b = {1'b0, lerp_q}; end
      ST_CU: begin mul_a = mag35(cu); mul_b = mag35(cu); end
      ST_CV: begin mul_a = mag35(cv); mul_b = mag35(cv); end
      default: ;
    endcase
    mul_start = !mul_pend_q &&
                ((st_q == ST_LEN_U) || (st_q == ST_LEN_V) || (st_q == ST_DOT_U) ||
                 (st_q == ST_DOT_V) || (st_q == ST_PU) || (st_q == ST_PV) ||
                 (st_q == ST_CU) || (st_q == ST_CV));
    div_start = !div_pend_q && (st_q == ST_DIV);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      mul_pend_q  <= 1'b0;
      div_pend_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (psel && penable && pwrite && (paddr[2] == REG_EDGE_COUNT)) begin
        cnt_q <= pwdata[10:0];
      end
      if (mul_start) begin
        mul_pend_q <= 1'b1;
      end else if (mul_done) begin
        mul_pend_q <= 1'b0;
      end
      if (div_start) begin
        div_pend_q <= 1'b1;
      end else if (div_done) begin
        div_pend_q <= 1'b0;
      end
      if (st_q == ST_IDLE && req_fire) begin
        n_q <= n_d;
        i_q <= '0;
      end else if (st_q == ST_CMP) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (out_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (req_fire) begin
          qu_q   <= req_i.query_u;
          qv_q   <= req_i.query_v;
          su_q   <= req_i.start_u;
          sv_q   <= req_i.start_v;
          du_q   <= 33'(req_i.end_u) - 33'(req_i.start_u);
          dv_q   <= 33'(req_i.end_v) - 33'(req_i.start_v);
          tri_q  <= req_i.owner_triangle;
          slot_q <= req_i.slot;
        end
      end
      ST_LEN_U, ST_CU: if (mul_done) dist_q <= {1'b0, mul_p};
      ST_LEN_V, ST_CV: if (mul_done) dist_q <= dist_q + {1'b0, mul_p};
      ST_W: begin
        wu_q  <= 33'(qu_q) - 33'(rd.start_u);
        wv_q  <= 33'(qv_q) - 33'(rd.start_v);
        du_q  <= rd.dir_u;
        dv_q  <= rd.dir_v;
        len_q <= rd.length_sq;
        tri_q <= rd.triangle;
      end
      ST_DOT_U: if (mul_done) dot_q <= term;
      ST_DOT_V: if (mul_done) dot_q <= dot_q + term;
      ST_LERP: begin
        if (lerp_zero) begin
          lerp_q <= '0;
        end else if (lerp_one) begin
          lerp_q <= 33'h1_0000_0000;
        end
      end
      ST_DIV: if (div_done) lerp_q <= {1'b0, div_q};
      // scale by the Q1.32 lerp and round to the nearest integer, half away from zero (on the magnitude)
      ST_PU: begin
        if (mul_done) begin
          pu_q <= du_q[32] ? -$signed({1'b0, rnd[64:32]}) : $signed({1'b0, rnd[64:32]});
        end
      end
      ST_PV: begin
        if (mul_done) begin
          pv_q <= dv_q[32] ? -$signed({1'b0, rnd[64:32]}) : $signed({1'b0, rnd[64:32]});
        end
      end
      ST_CMP: begin
        // strict compare keeps the lowest index on a tie
        if (i_q == '0 || dsat < best_d_q) begin
          best_d_q   <= dsat;
          best_i_q   <= i_q[ADDR_W-1:0];
          best_tri_q <= tri_q;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          if (n_q == '0) begin
            rsp_empty_q <= 1'b1;
            rsp_edge_q  <= '0;
            rsp_tri_q   <= '0;
            rsp_dist_q  <= DIST_MAX;
          end else begin
            rsp_empty_q <= 1'b0;
            rsp_edge_q  <= 10'(best_i_q);
            rsp_tri_q   <= best_tri_q;
            rsp_dist_q  <= best_d_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.closest_edge     = rsp_edge_q;
  assign rsp_o.triangle         = rsp_tri_q;
  assign rsp_o.distance_squared = rsp_dist_q;
  assign rsp_o.table_empty      = rsp_empty_q;

endmodule

>>> design/css_chk.sv
// Port-level checker for the closest segment search unit, with its bind.
`timescale 1ns / 1ps
module css_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_opcode,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [9:0]  rsp_edge,
  input logic [19:0] rsp_tri,
  input logic [62:0] rsp_dist,
  input logic        rsp_empty
);
  import css_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_dist) && $stable(rsp_edge))
    else $error("response payload changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_empty |-> rsp_dist == DIST_MAX && rsp_edge == '0 && rsp_tri == '0)
    else $error("empty-table response malformed");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_opcode == OP_LOAD |=> !$rose(rsp_valid))
    else $error("load request produced a response");

endmodule

bind closest_segment_search_unit css_chk u_css_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req_i.valid),
  .req_ready  (req_i.ready),
  .req_opcode (req_i.opcode),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_edge   (rsp_o.closest_edge),
  .rsp_tri    (rsp_o.triangle),
  .rsp_dist   (rsp_o.distance_squared),
  .rsp_empty  (rsp_o.table_empty)
);

>>> sim/tb.sv
// Testbench for the closest segment search unit: segment loads, searches and backpressure.
`timescale 1ns / 1ps
module tb;
  import css_pkg::*;

  localparam int    WATCHDOG_LIMIT = 300000;
  localparam int    LOAD_SETTLE = 40;
  localparam int    HOLD_CYCLES = 400;
  localparam int    TAIL_CYCLES = 200;
  localparam int    FULL_SLOTS = 300;
  localparam logic [2:0] ADDR_EDGE_COUNT = 3'd0;

  typedef struct {
    logic signed [31:0] su;
    logic signed [31:0] sv;
    logic signed [32:0] du;
    logic signed [32:0] dv;
    logic [63:0]        len;
    logic [19:0]        tri_idx;
  } segment_t;

  typedef struct {
    logic [9:0]  closest;
    logic [19:0] tri_idx;
    logic [62:0] dist_sq;
    logic        empty;
  } nearest_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  css_req_if req_if ();
  css_rsp_if rsp_if ();

  closest_segment_search_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  segment_t seg_table [MAX_SEGMENTS];
  int       loaded_top;      // slots 0 .. loaded_top-1 hold data
  int       edge_count_q;
  nearest_t nearest_q[$];

  int  mismatches;
  int  n_loads, n_queries, n_results;
  int  idle_cycles;
  bit  quiet;
  bit  hold_rsp;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [62:0] segment_distance(int i, logic signed [31:0] qu,
                                                   logic signed [31:0] qv);
    logic signed [127:0] wu, wv, du, dv, dot, len, lerp, m, pu, pv, cu, cv, dsq;
    wu = qu - seg_table[i].su;
    wv = qv - seg_table[i].sv;
    du = seg_table[i].du;
    dv = seg_table[i].dv;
    len = {64'd0, seg_table[i].len};
    dot = wu * du + wv * dv;
    if (len == 0 || dot <= 0) begin
      lerp = 0;
    end else if (dot >= len) begin
      lerp = 128'sh1_0000_0000;
    end else begin
      lerp = (dot <<< 32) / len;
    end
    m  = ((du < 0 ? -du : du) * lerp + 128'sh8000_0000) >>> 32;
    pu = du < 0 ? -m : m;
    m  = ((dv < 0 ? -dv : dv) * lerp + 128'sh8000_0000) >>> 32;
    pv = dv < 0 ? -m : m;
    cu = pu - wu;
    cv = pv - wv;
    dsq = cu * cu + cv * cv;
    if (dsq[127:63] != 0) return DIST_MAX;
    return dsq[62:0];
  endfunction

  function automatic nearest_t find_nearest(logic signed [31:0] qu, logic signed [31:0] qv);
    nearest_t r;
    logic [62:0] d;
    int n;
    n = edge_count_q > MAX_SEGMENTS ? MAX_SEGMENTS : edge_count_q;
    r.closest = '0;
    r.tri_idx = '0;
    r.dist_sq = DIST_MAX;
    r.empty   = (n == 0);
    for (int i = 0; i < n; i++) begin
      d = segment_distance(i, qu, qv);
      if (i == 0 || d < r.dist_sq) begin
        r.dist_sq = d;
        r.closest = i[9:0];
        r.tri_idx = seg_table[i].tri_idx;
      end
    end
    return r;
  endfunction

  function automatic void store_segment(int slot, logic signed [31:0] su, logic signed [31:0] sv,
                                        logic signed [31:0] eu, logic signed [31:0] ev,
                                        logic [19:0] tri_idx);
    logic signed [32:0]  du, dv;
    logic signed [127:0] len;
    du = eu - su;
    dv = ev - sv;
    len = du * du + dv * dv;
    seg_table[slot].su = su;
    seg_table[slot].sv = sv;
    seg_table[slot].du = du;
    seg_table[slot].dv = dv;
    seg_table[slot].len = (len[127:64] != 0) ? {64{1'b1}} : len[63:0];
    seg_table[slot].tri_idx = tri_idx;
    if (slot == loaded_top) loaded_top++;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_request(logic op, logic [9:0] slot, logic signed [31:0] su,
                              logic signed [31:0] sv, logic signed [31:0] eu,
                              logic signed [31:0] ev, logic [19:0] tri_idx,
                              logic signed [31:0] qu, logic signed [31:0] qv);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_if.valid = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    req_if.valid          = 1'b1;
    req_if.opcode         = op;
    req_if.slot           = slot;
    req_if.start_u        = su;
    req_if.start_v        = sv;
    req_if.end_u          = eu;
    req_if.end_v          = ev;
    req_if.owner_triangle = tri_idx;
    req_if.query_u        = qu;
    req_if.query_v        = qv;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      store_segment(slot, su, sv, eu, ev, tri_idx);
      n_loads++;
    end else begin
      nearest_q.insert(nearest_q.size(), find_nearest(qu, qv));
      n_queries++;
    end
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic load_segment(int slot, logic signed [31:0] su, logic signed [31:0] sv,
                              logic signed [31:0] eu, logic signed [31:0] ev,
                              logic [19:0] tri_idx);
    send_request(OP_LOAD, slot[9:0], su, sv, eu, ev, tri_idx, $urandom, $urandom);
  endtask

  task automatic query_point(logic signed [31:0] qu, logic signed [31:0] qv);
    send_request(OP_QUERY, 10'($urandom), $urandom, $urandom, $urandom, $urandom,
                 20'($urandom), qu, qv);
  endtask

  // wait for every pending result, then let a trailing load settle
  task automatic wait_idle();
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (LOAD_SETTLE) @(negedge clk);
  endtask

  task automatic write_edge_count(int value);
    wait_idle();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = ADDR_EDGE_COUNT; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    edge_count_q = value & 32'h7FF;
    @(negedge clk);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[10:0] != edge_count_q[10:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("edge_count readback: expected %0d got %0d", edge_count_q, prdata[10:0]);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 2) == 0 ? 32'sh8000_0000 :
                      ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sd0);
      2:       return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  task automatic load_random(int slot);
    logic signed [31:0] su, sv;
    su = rand_coord();
    sv = rand_coord();
    if ($urandom_range(0, 9) == 0) load_segment(slot, su, sv, su, sv, 20'($urandom));
    else load_segment(slot, su, sv, rand_coord(), rand_coord(), 20'($urandom));
  endtask

  // ---------------------------------------------------------------- response side
  always @(negedge clk) begin
    if (hold_rsp) begin
      rsp_if.ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_rsp = 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rsp_if.ready = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    nearest_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      n_results++;
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: edge %0d", rsp_if.closest_edge);
      end else begin
        e = nearest_q.pop_front();
        if (rsp_if.closest_edge !== e.closest || rsp_if.triangle !== e.tri_idx ||
            rsp_if.distance_squared !== e.dist_sq || rsp_if.table_empty !== e.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected edge %0d tri %0d dist %h empty %b, got %0d %0d %h %b",
                     e.closest, e.tri_idx, e.dist_sq, e.empty, rsp_if.closest_edge,
                     rsp_if.triangle, rsp_if.distance_squared, rsp_if.table_empty);
        end
      end
    end
  end

  // watchdog: cycles with no request, result or register access accepted
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_empty_table();
    query_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    query_point(32'sd0, 32'sd0);
  endtask

  task automatic test_directed();
    load_segment(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'hFFFFF);
    load_segment(1, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 20'h0);
    load_segment(2, 32'sh0000_0000, 32'sh0000_0000, 32'sh0004_0000, 32'sh0000_0000, 20'h12345);
    load_segment(3, 32'sh0000_0000, 32'sh0000_0000, 32'sh0004_0000, 32'sh0000_0000, 20'h54321);
    load_segment(4, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 20'hAAAAA);
    load_segment(5, 32'sh0000_0003, 32'shFFFF_FFFD, 32'sh0000_0007, 32'sh0000_0005, 20'h55555);
    write_edge_count(6);
    query_point(32'sh0002_0000, 32'sh0000_8000);  // projects inside the duplicate pair
    query_point(32'sh8000_0000, 32'sh8000_0000);
    query_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    query_point(32'sh0001_0000, 32'sh0001_0000);  // on the zero-length segment
    query_point(32'shFFFF_0000, 32'sh0000_0000);  // before the start: lerp clamps to 0
    query_point(32'sh0010_0000, 32'sh0000_0001);  // past the end: lerp clamps to 1
    query_point(32'sh0000_0005, 32'sh0000_0001);
    write_edge_count(1);
    query_point(32'sh8000_0000, 32'sh7FFF_FFFF);
  endtask

  task automatic test_full_table();
    for (int s = 0; s < FULL_SLOTS; s++) load_random(s);
    write_edge_count(FULL_SLOTS);
    query_point(rand_coord(), rand_coord());
    query_point(32'sd0, 32'sd0);
  endtask

  task automatic test_random_mix(int items);
    for (int k = 0; k < items; k++) begin
      if (k % 70 == 0) write_edge_count($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      if ($urandom_range(0, 9) < 4) begin
        load_random($urandom_range(0, 9) == 0 ? $urandom_range(0, MAX_SEGMENTS - 1)
                                             : $urandom_range(0, 15));
      end else begin
        query_point(rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic test_backpressure();
    write_edge_count(4);
    hold_rsp = 1'b1;
    for (int k = 0; k < 12; k++) query_point(rand_coord(), rand_coord());
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.opcode = OP_LOAD; req_if.slot = '0;
    req_if.start_u = '0; req_if.start_v = '0; req_if.end_u = '0; req_if.end_v = '0;
    req_if.owner_triangle = '0; req_if.query_u = '0; req_if.query_v = '0;
    rsp_if.ready = 1'b0;
    quiet = 1'b0; hold_rsp = 1'b0;
    edge_count_q = 0; loaded_top = 0; mismatches = 0;
    n_loads = 0; n_queries = 0; n_results = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_directed();
    test_full_table();
    test_random_mix(190);
    test_backpressure();
    quiet = 1'b1;
    test_random_mix(60);

    while (nearest_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d loads and %0d searches (%0d results), table sizes 0 to %0d",
             n_loads, n_queries, n_results, FULL_SLOTS);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
